@@ rtl/rlsg_pkg.sv @@
// Shared types, constants and helpers for the random line shift glitch block.
// No dependencies.
package rlsg_pkg;

	localparam logic [31:0] LCG_MUL  = 32'd1103515245;
	localparam logic [31:0] LCG_ADD  = 32'd12345;
	localparam logic [31:0] SEED_TOP = 32'hffff_fffe;
	localparam logic [10:0] PASS_TOP = 11'd101;
	localparam logic [10:0] RANGE_CAP = 11'd1024;

	typedef enum logic [1:0] {
		CMD_PIXEL  = 2'd0,
		CMD_FLUSH  = 2'd1,
		CMD_RESEED = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_SEED            = 3'd0,
		REG_GLITCH_CHANCE   = 3'd1,
		REG_MAX_BLOCK_LINES = 3'd2,
		REG_MAX_SHIFT       = 3'd3,
		REG_COLOR_INTENSITY = 3'd4,
		REG_LINE_WIDTH      = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		MODE_KEEP   = 3'd0,
		MODE_INVERT = 3'd1,
		MODE_OR     = 3'd2,
		MODE_XOR    = 3'd3,
		MODE_AND    = 3'd4
	} mode_t;

	// Clamp an 11-bit range register into 1..RANGE_CAP.
	function automatic logic [10:0] clamp_range(input logic [10:0] v);
		logic [10:0] r;
		r = v;
		if (v == 11'd0) r = 11'd1;
		else if (v > RANGE_CAP) r = RANGE_CAP;
		return r;
	endfunction

	// Apply a color distortion; alpha always kept.
	function automatic logic [31:0] distort(input logic [31:0] pix, input logic [31:0] key,
		input logic [2:0] mode);
		logic [31:0] r;
		case (mode)
			MODE_INVERT: r = ~pix;
			MODE_OR:     r = pix | key;
			MODE_XOR:    r = pix ^ key;
			MODE_AND:    r = pix & key;
			default:     r = pix;
		endcase
		return {pix[31:24], r[23:0]};
	endfunction

endpackage

@@ rtl/rlsg_if.sv @@
// Valid/ready channel interfaces for the pixel input and pixel output.
// Depends on nothing.
interface rlsg_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] in_pixel;
	logic        start_of_frame;
	modport source (output valid, command, in_pixel, start_of_frame, input ready);
	modport sink   (input valid, command, in_pixel, start_of_frame, output ready);
endinterface

interface rlsg_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_pixel;
	logic        line_end;
	logic        frame_end;
	modport source (output valid, out_pixel, line_end, frame_end, input ready);
	modport sink   (input valid, out_pixel, line_end, frame_end, output ready);
endinterface

@@ rtl/rlsg_rem.sv @@
// Bit-serial remainder unit: 32-bit dividend modulo an 11-bit nonzero divisor.
// One quotient bit per cycle; no package dependency.
module rlsg_rem (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [10:0] divisor,
	output logic        done,
	output logic [10:0] rem
);
	logic [31:0] dvd_q;
	logic [10:0] div_q;
	logic [10:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [11:0] trial;

	assign trial = {rem_q, dvd_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (trial >= {1'b0, div_q}) rem_q <= 11'(trial - {1'b0, div_q});
			else rem_q <= trial[10:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule

@@ rtl/random_line_shift_glitch.sv @@
// Top level of the random line shift glitch block: sequencer, line store, LCG.
// Depends on rlsg_pkg, rlsg_if and rlsg_rem.
// Latency: an item that reads the held line passes the prepare, read and emit states before its
// result is presented; draws of block parameters, by remainder or by seed, come in between.
// Throughput: one item at a time; a new item is taken only back in idle, so draws (above all
// the bit-serial remainder draws) and a stalled output hold the flow.
// Reset: all control and block state clears, registers take their documented defaults.
module random_line_shift_glitch
	import rlsg_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_data,
	rlsg_in_if.sink     in_ch,
	rlsg_out_if.source  out_ch
);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int AW = $clog2(2 * MAX_WIDTH);

	typedef enum logic [2:0] {
		ST_IDLE, ST_PREP, ST_DRAW_LCG, ST_DRAW_USE, ST_DRAW_WAIT, ST_READ, ST_EMIT, ST_UPDATE
	} state_t;

	typedef enum logic [2:0] {
		DR_BLEN, DR_ROT, DR_PASS, DR_SEED1, DR_SEED2, DR_MODE1, DR_MODE2
	} draw_t;

	// Configuration registers
	logic [31:0] seed_q;
	logic [6:0]  chance_q;
	logic [10:0] max_blk_q, max_shift_q, lwidth_q;
	logic [2:0]  intensity_q;

	// Block and line state
	logic [31:0] rnd_q, key1_q, key2_q;
	logic [10:0] blen_q, lib_q, rot_q;
	logic [2:0]  mode1_q, mode2_q;
	logic        pass_q, bank_q, held_q, hfe_q;
	logic [CW-1:0] column_q;

	// Sequencer
	state_t state_q;
	draw_t  draw_q;
	logic   draw_full_q;
	state_t draw_ret_q;
	cmd_t   cmd_q;
	logic [31:0] pix_q;
	logic   sof_q, last_q;
	logic [WW-1:0] s_q, first_q;
	logic [31:0] key_q;
	logic [2:0]  mode_q;
	logic        dist_q;

	// Line store
	logic [31:0] mem [2*MAX_WIDTH];
	logic [31:0] rd_q;
	logic [AW-1:0] rd_addr, wr_addr;
	logic          mem_we;

	// Output register
	logic        out_v_q;
	logic [31:0] out_pix_q;
	logic        out_le_q, out_fe_q;

	// Remainder unit
	logic        rem_start, rem_done;
	logic [10:0] rem_span, rem_val, draw_val;

	// Combinational helpers
	logic [WW-1:0] w_c, s_c, p_c, src_c;
	logic [CW-1:0] col_c;
	logic          last_c, emit_ok, draw_seed, draw_last;
	draw_t         draw_next;

	assign in_ch.ready = (state_q == ST_IDLE);

	// Active width clamped into 1..MAX_WIDTH; current column clamped below it.
	always_comb begin
		if (lwidth_q == 11'd0) w_c = WW'(1);
		else if (32'(lwidth_q) > 32'(MAX_WIDTH)) w_c = WW'(MAX_WIDTH);
		else w_c = WW'(lwidth_q);
		if (32'(column_q) >= 32'(w_c)) col_c = CW'(w_c - WW'(1));
		else col_c = column_q;
		last_c = (32'(col_c) + 32'd1) >= 32'(w_c);
		if (32'(rot_q) < 32'(w_c)) s_c = WW'(rot_q);
		else s_c = w_c;
	end

	// Source column of the held line after rotation.
	always_comb begin
		p_c = WW'(column_q);
		if (pass_q) src_c = p_c;
		else if (p_c < first_q) src_c = p_c + s_q;
		else src_c = p_c - first_q;
		if (!bank_q) rd_addr = AW'(MAX_WIDTH) + AW'(src_c[CW-1:0]);
		else rd_addr = AW'(src_c[CW-1:0]);
		if (bank_q) wr_addr = AW'(MAX_WIDTH) + AW'(column_q);
		else wr_addr = AW'(column_q);
	end

	assign mem_we = (state_q == ST_UPDATE) && (cmd_q == CMD_PIXEL);

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= pix_q;
		rd_q <= mem[rd_addr];
	end

	// Draw unit control: span of the current draw and what follows it.
	always_comb begin
		draw_seed = (draw_q == DR_SEED1) || (draw_q == DR_SEED2);
		case (draw_q)
			DR_BLEN: rem_span = clamp_range(max_blk_q);
			DR_ROT:  rem_span = clamp_range(max_shift_q);
			DR_PASS: rem_span = PASS_TOP;
			default: rem_span = 11'(intensity_q) + 11'd1;
		endcase
		draw_last = 1'b0;
		draw_next = draw_q;
		case (draw_q)
			DR_BLEN:  begin draw_next = DR_ROT; draw_last = !draw_full_q; end
			DR_ROT:   draw_next = DR_PASS;
			DR_PASS:  begin draw_next = DR_SEED1; draw_last = (intensity_q == 3'd0); end
			DR_SEED1: draw_next = DR_SEED2;
			DR_SEED2: draw_next = DR_MODE1;
			DR_MODE1: draw_next = DR_MODE2;
			default:  draw_last = 1'b1;
		endcase
	end

	assign rem_start = (state_q == ST_DRAW_USE) && !draw_seed;
	assign draw_val  = rem_val + 11'd1;

	rlsg_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (rnd_q),
		.divisor  (rem_span),
		.done     (rem_done),
		.rem      (rem_val)
	);

	assign emit_ok = !out_v_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= '0;
			chance_q    <= '0;
			max_blk_q   <= 11'd512;
			max_shift_q <= 11'd512;
			intensity_q <= 3'd3;
			lwidth_q    <= 11'd1024;
			rnd_q       <= '0;
			key1_q      <= '0;
			key2_q      <= '0;
			blen_q      <= '0;
			lib_q       <= '0;
			rot_q       <= '0;
			mode1_q     <= '0;
			mode2_q     <= '0;
			pass_q      <= 1'b0;
			bank_q      <= 1'b0;
			held_q      <= 1'b0;
			hfe_q       <= 1'b0;
			column_q    <= '0;
			state_q     <= ST_IDLE;
			draw_q      <= DR_BLEN;
			draw_full_q <= 1'b0;
			draw_ret_q  <= ST_IDLE;
			cmd_q       <= CMD_NONE;
			last_q      <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_SEED:            seed_q      <= cfg_data;
					REG_GLITCH_CHANCE:   chance_q    <= cfg_data[6:0];
					REG_MAX_BLOCK_LINES: max_blk_q   <= cfg_data[10:0];
					REG_MAX_SHIFT:       max_shift_q <= cfg_data[10:0];
					REG_COLOR_INTENSITY: intensity_q <= cfg_data[2:0];
					REG_LINE_WIDTH:      lwidth_q    <= cfg_data[10:0];
					default: ;
				endcase
			end
			// Drain the result; the emit state reloads it in the same cycle.
			if (out_v_q && out_ch.ready && state_q != ST_EMIT) out_v_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						cmd_q   <= cmd_t'(in_ch.command);
						state_q <= ST_PREP;
					end
				end
				// Clamp column, latch rotation split, then dispatch on command.
				ST_PREP: begin
					column_q <= col_c;
					last_q   <= last_c;
					case (cmd_q)
						CMD_RESEED: begin
							rnd_q       <= seed_q;
							draw_q      <= DR_BLEN;
							draw_full_q <= 1'b1;
							lib_q       <= '0;
							draw_ret_q  <= ST_IDLE;
							state_q     <= ST_DRAW_LCG;
						end
						CMD_FLUSH: state_q <= held_q ? ST_READ : ST_IDLE;
						CMD_PIXEL: begin
							if (sof_q && col_c == '0) begin
								hfe_q       <= held_q;
								draw_q      <= DR_BLEN;
								draw_full_q <= 1'b0;
								draw_ret_q  <= held_q ? ST_READ : ST_UPDATE;
								state_q     <= ST_DRAW_LCG;
							end else begin
								state_q <= held_q ? ST_READ : ST_UPDATE;
							end
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_DRAW_LCG: begin
					rnd_q   <= rnd_q * LCG_MUL + LCG_ADD;
					state_q <= ST_DRAW_USE;
				end
				ST_DRAW_USE: begin
					if (draw_seed) begin
						if (draw_q == DR_SEED1) key1_q <= (rnd_q > SEED_TOP) ? '0 : rnd_q;
						else key2_q <= (rnd_q > SEED_TOP) ? '0 : rnd_q;
						draw_q  <= draw_next;
						state_q <= draw_last ? draw_ret_q : ST_DRAW_LCG;
					end else begin
						state_q <= ST_DRAW_WAIT;
					end
				end
				ST_DRAW_WAIT: begin
					if (rem_done) begin
						case (draw_q)
							DR_BLEN:  blen_q  <= draw_val;
							DR_ROT:   rot_q   <= draw_val;
							DR_PASS:  pass_q  <= (11'(chance_q) < draw_val);
							DR_MODE1: mode1_q <= rem_val[2:0];
							default:  mode2_q <= rem_val[2:0];
						endcase
						draw_q  <= draw_next;
						state_q <= draw_last ? draw_ret_q : ST_DRAW_LCG;
					end
				end
				ST_READ: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (emit_ok) begin
						out_v_q <= 1'b1;
						state_q <= ST_UPDATE;
					end
				end
				// Store a pixel, advance the column; at line end swap banks or drop a flushed line.
				ST_UPDATE: begin
					if (cmd_q == CMD_FLUSH) begin
						state_q <= ST_IDLE;
						if (last_q) begin
							held_q   <= 1'b0;
							hfe_q    <= 1'b0;
							column_q <= '0;
						end else begin
							column_q <= column_q + CW'(1);
						end
					end else if (last_q) begin
						bank_q   <= ~bank_q;
						held_q   <= 1'b1;
						hfe_q    <= 1'b0;
						column_q <= '0;
						if (lib_q > blen_q) begin
							lib_q       <= '0;
							draw_q      <= DR_BLEN;
							draw_full_q <= 1'b1;
							draw_ret_q  <= ST_IDLE;
							state_q     <= ST_DRAW_LCG;
						end else begin
							lib_q   <= lib_q + 11'd1;
							state_q <= ST_IDLE;
						end
					end else begin
						state_q  <= ST_IDLE;
						column_q <= column_q + CW'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers: input item, rotation split, pixel selection, result.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid) begin
			pix_q <= in_ch.in_pixel;
			sof_q <= in_ch.start_of_frame;
		end
		if (state_q == ST_PREP) begin
			s_q     <= s_c;
			first_q <= w_c - s_c;
		end
		if (state_q == ST_READ) begin
			dist_q <= !pass_q && (intensity_q != 3'd0);
			if (p_c < first_q) begin
				key_q  <= key1_q;
				mode_q <= mode1_q;
			end else begin
				key_q  <= key2_q;
				mode_q <= mode2_q;
			end
		end
		if (state_q == ST_EMIT && emit_ok) begin
			out_pix_q <= dist_q ? distort(rd_q, key_q, mode_q) : rd_q;
			out_le_q  <= last_q;
			out_fe_q  <= (cmd_q == CMD_FLUSH) ? last_q : (last_q & hfe_q);
		end
	end

	assign out_ch.valid     = out_v_q;
	assign out_ch.out_pixel = out_pix_q;
	assign out_ch.line_end  = out_le_q;
	assign out_ch.frame_end = out_fe_q;

	// The remainder unit reports only while a draw waits for it.
	a_rem_done: assert property (@(posedge clk) disable iff (!arst_n)
		rem_done |-> state_q == ST_DRAW_WAIT)
		else $error("remainder done outside draw wait");

	// The held line empties only through the last pixel of a flush.
	a_held_fell: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(held_q) |-> $past(state_q == ST_UPDATE && cmd_q == CMD_FLUSH && last_q))
		else $error("held line dropped without flush");

	// An accepted item holds off ready in the following cycle.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("second item taken while busy");

	// A result is loaded only when the output register is free or draining.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_v_q && !out_ch.ready) |=> state_q == ST_EMIT)
		else $error("result overwritten");
endmodule
